// ===== hw/rtl/open_band_lru_table_macros.svh =====
`ifndef OPEN_BAND_LRU_TABLE_MACROS_SVH
`define OPEN_BAND_LRU_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define OBLT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define OBLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== hw/rtl/oblt_pkg.sv =====
package oblt_pkg;

	localparam int BAND_W    = 31;
	localparam int CAP_W     = 5;
	localparam int SLOT_O_W  = 4;
	localparam int COUNT_O_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		CMD_ACCESS = 1'b0,
		CMD_FLUSH  = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t              command;
		logic              write_access;
		logic [BAND_W-1:0] band_num;
	} item_t;

	// lowest field first on the wire, so it sits last here
	typedef struct packed {
		logic [COUNT_O_W-1:0] closed_count;
		logic [COUNT_O_W-1:0] open_count;
		logic [SLOT_O_W-1:0]  slot;
		logic [BAND_W-1:0]    evicted_band;
		logic                 evicted;
		logic                 reopened_for_write;
		logic                 hit;
	} result_t;

	typedef struct packed {
		logic hit;
		logic reopen;
		logic evict;
		logic insert;
	} lookup_flags_t;

endpackage

// ===== hw/rtl/oblt_lookup.sv =====
module oblt_lookup #(
	parameter int MAX_ENTRIES = 16,
	localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1),
	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  oblt_pkg::item_t                                   item,
	input  logic [oblt_pkg::CAP_W-1:0]                        capacity,
	input  logic [MAX_ENTRIES-1:0]                            valid,
	input  logic [MAX_ENTRIES-1:0][oblt_pkg::BAND_W-1:0]      band,
	input  logic [MAX_ENTRIES-1:0]                            writable,
	input  logic [MAX_ENTRIES-1:0][RANK_W-1:0]                rank,
	input  logic [CNT_W-1:0]                                  count,
	output oblt_pkg::lookup_flags_t                           flags,
	output logic [MAX_ENTRIES-1:0]                            hit_oh,
	output logic [MAX_ENTRIES-1:0]                            free_oh,
	output logic [MAX_ENTRIES-1:0]                            valid_after,
	output logic [RANK_W-1:0]                                 hit_rank,
	output logic [IDX_W-1:0]                                  slot_idx,
	output logic [oblt_pkg::BAND_W-1:0]                       evicted_band,
	output logic [CNT_W-1:0]                                  open_after
);
	import oblt_pkg::*;

	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [MAX_ENTRIES-1:0] hit_vec;
	logic [MAX_ENTRIES-1:0] victim_vec;
	logic [MAX_ENTRIES-1:0] victim_oh;
	logic [MAX_ENTRIES-1:0] free_vec;
	logic [MAX_ENTRIES-1:0] pick_oh;
	logic [CMP_W-1:0]       cap_eff;
	logic                   full;
	logic                   hit_writable;

	always_comb begin
		cap_eff = CMP_W'(capacity);
		if (cap_eff == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_eff > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CMP_W'(MAX_ENTRIES);
		end
		full = (CMP_W'(count) >= cap_eff);
	end

	// tag compare and victim search across all slots at once
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_vec[i]    = valid[i] && (band[i] == item.band_num);
			victim_vec[i] = valid[i] && ((CNT_W'(rank[i]) + CNT_W'(1)) == count);
		end
		hit_oh    = hit_vec & (~hit_vec + MAX_ENTRIES'(1));
		victim_oh = victim_vec & (~victim_vec + MAX_ENTRIES'(1));
	end

	always_comb begin
		flags.hit   = |hit_vec;
		flags.evict = !flags.hit && full && (|victim_vec);

		valid_after = valid & ~(flags.evict ? victim_oh : '0);
		free_vec    = ~valid_after;
		free_oh     = free_vec & (~free_vec + MAX_ENTRIES'(1));
		flags.insert = !flags.hit && (|free_vec);

		hit_rank     = '0;
		hit_writable = 1'b0;
		evicted_band = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (hit_oh[i]) begin
				hit_rank     = hit_rank | rank[i];
				hit_writable = hit_writable | writable[i];
			end
			if (flags.evict && victim_oh[i]) begin
				evicted_band = evicted_band | band[i];
			end
		end
		flags.reopen = flags.hit && item.write_access && !hit_writable;

		pick_oh = flags.hit ? hit_oh : (flags.insert ? free_oh : '0);
		slot_idx = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (pick_oh[i]) begin
				slot_idx = slot_idx | IDX_W'(i);
			end
		end

		open_after = count - CNT_W'(flags.evict) + CNT_W'(flags.insert);
	end

endmodule

// ===== hw/rtl/oblt_table.sv =====
module oblt_table #(
	parameter int MAX_ENTRIES = 16,
	localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          access_en,
	input  logic                                          flush_en,
	input  oblt_pkg::item_t                               item,
	input  oblt_pkg::lookup_flags_t                       flags,
	input  logic [MAX_ENTRIES-1:0]                        hit_oh,
	input  logic [MAX_ENTRIES-1:0]                        free_oh,
	input  logic [MAX_ENTRIES-1:0]                        valid_after,
	input  logic [RANK_W-1:0]                             hit_rank,
	input  logic [CNT_W-1:0]                              open_after,
	output logic [MAX_ENTRIES-1:0]                        valid_q,
	output logic [MAX_ENTRIES-1:0][oblt_pkg::BAND_W-1:0]  band_q,
	output logic [MAX_ENTRIES-1:0]                        writable_q,
	output logic [MAX_ENTRIES-1:0][RANK_W-1:0]            rank_q,
	output logic [CNT_W-1:0]                              count_q
);
	import oblt_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (flush_en) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (access_en) begin
			valid_q <= valid_after | (flags.insert ? free_oh : '0);
			count_q <= open_after;
		end
	end

	// entry payload: meaningful only while the slot is valid
	always_ff @(posedge clk) begin
		if (access_en) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (flags.hit) begin
					if (hit_oh[i]) begin
						rank_q[i] <= '0;
						if (item.write_access) begin
							writable_q[i] <= 1'b1;
						end
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end else if (flags.insert) begin
					if (free_oh[i]) begin
						band_q[i]     <= item.band_num;
						writable_q[i] <= item.write_access;
						rank_q[i]     <= '0;
					end else if (valid_after[i]) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
			end
		end
	end

endmodule

// ===== hw/rtl/open_band_lru_table.sv =====
// Channel   Dir  Transaction                 Payload
// s_axis    in   one access or flush         tdata: band, write_access; tuser: command
// m_axis    out  one result per input        tdata: hit .. closed_count (48 bits)
// cfg       in   capacity write, no wait     cfg_wr_data: capacity
//
// Takes one item per cycle while m_axis is not stalled; each accepted item passes through the input
// register and then the output register before its result is offered.
// The rate is set by the single pass through tag compare and rank update, which writes
// the table in the same cycle that loads the result register.
// Reset clears all valid bits and the open count and sets capacity to 16.
// A stalled result holds in the output register; the input register then fills and
// s_axis_tready drops until the result is taken.
module open_band_lru_table #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,  // band[30:0], write_access[31]
	input  logic                          s_axis_tuser,  // command
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// hit[0], reopened_for_write[1], evicted[2], evicted_band[33:3], slot[37:34],
	// open_count[42:38], closed_count[47:43]
	output logic [47:0]                   m_axis_tdata,
	input  logic                          cfg_wr_en,
	input  logic [oblt_pkg::CAP_W-1:0]    cfg_wr_data
);
	import oblt_pkg::*;

	localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [CAP_W-1:0] capacity_q;
	item_t            item_s1;
	logic             valid_s1;
	result_t          result_s2;
	logic             valid_s2;
	logic             advance;
	logic             fire;
	result_t          result_d;

	logic [MAX_ENTRIES-1:0]              valid_q;
	logic [MAX_ENTRIES-1:0][BAND_W-1:0]  band_q;
	logic [MAX_ENTRIES-1:0]              writable_q;
	logic [MAX_ENTRIES-1:0][RANK_W-1:0]  rank_q;
	logic [CNT_W-1:0]                    count_q;

	lookup_flags_t          flags;
	logic [MAX_ENTRIES-1:0] hit_oh;
	logic [MAX_ENTRIES-1:0] free_oh;
	logic [MAX_ENTRIES-1:0] valid_after;
	logic [RANK_W-1:0]      hit_rank;
	logic [IDX_W-1:0]       slot_idx;
	logic [BAND_W-1:0]      evicted_band;
	logic [CNT_W-1:0]       open_after;

	assign advance       = !valid_s2 || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.command      <= cmd_t'(s_axis_tuser);
			item_s1.write_access <= s_axis_tdata[31];
			item_s1.band_num     <= s_axis_tdata[BAND_W-1:0];
		end
		if (fire) begin
			result_s2 <= result_d;
		end
	end

	oblt_lookup #(.MAX_ENTRIES(MAX_ENTRIES)) u_lookup (
		.item         (item_s1),
		.capacity     (capacity_q),
		.valid        (valid_q),
		.band         (band_q),
		.writable     (writable_q),
		.rank         (rank_q),
		.count        (count_q),
		.flags        (flags),
		.hit_oh       (hit_oh),
		.free_oh      (free_oh),
		.valid_after  (valid_after),
		.hit_rank     (hit_rank),
		.slot_idx     (slot_idx),
		.evicted_band (evicted_band),
		.open_after   (open_after)
	);

	oblt_table #(.MAX_ENTRIES(MAX_ENTRIES)) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.access_en   (fire && (item_s1.command == CMD_ACCESS)),
		.flush_en    (fire && (item_s1.command == CMD_FLUSH)),
		.item        (item_s1),
		.flags       (flags),
		.hit_oh      (hit_oh),
		.free_oh     (free_oh),
		.valid_after (valid_after),
		.hit_rank    (hit_rank),
		.open_after  (open_after),
		.valid_q     (valid_q),
		.band_q      (band_q),
		.writable_q  (writable_q),
		.rank_q      (rank_q),
		.count_q     (count_q)
	);

	always_comb begin
		result_d = '0;
		unique case (item_s1.command)
			CMD_FLUSH: begin
				result_d.closed_count = COUNT_O_W'(count_q);
			end
			CMD_ACCESS: begin
				result_d.hit                = flags.hit;
				result_d.reopened_for_write = flags.reopen;
				result_d.evicted            = flags.evict;
				result_d.evicted_band       = evicted_band;
				result_d.slot               = SLOT_O_W'(slot_idx);
				result_d.open_count         = COUNT_O_W'(open_after);
			end
			default: begin
				result_d = '0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/oblt_checker.sv =====
`include "open_band_lru_table_macros.svh"

module oblt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	// hold a stalled result
	`OBLT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// a flush that closed entries reports nothing else
	`OBLT_ASSERT_NOW(a_flush_clean, m_axis_tvalid && (m_axis_tdata[47:43] != 5'd0), m_axis_tdata[42:0] == 43'd0)

	// a hit never evicts and never reports an evicted band
	`OBLT_ASSERT_NOW(a_hit_no_evict, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[2] && (m_axis_tdata[33:3] == 31'd0))

	// an upgrade to writable only happens on a hit
	`OBLT_ASSERT_NOW(a_reopen_hit, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0])

endmodule

bind open_band_lru_table oblt_checker u_oblt_checker (.*);

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import oblt_pkg::*;

	localparam int SLOTS     = 16;
	localparam int LIMIT     = 200000;
	localparam int LONG_HOLD = 400;
	localparam int PHASE_LEN = 220;

	// Mirrors the band table: per-slot state, LRU ranks and the capacity register.
	class lru_band_scoreboard;
		logic [CAP_W-1:0]  capacity;
		bit                slot_open[SLOTS];
		logic [BAND_W-1:0] slot_band[SLOTS];
		bit                slot_writable[SLOTS];
		int                slot_rank[SLOTS];
		result_t           expected_results[$];
		int                errors;
		int                accepted;
		int                hits;
		int                reopens;
		int                evictions;
		int                flushes;

		function new();
			capacity = CAP_RESET;
		endfunction

		// Age every open entry more recent than old_rank, then put s on top.
		function void promote(int s, int old_rank);
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_open[i] && i != s && slot_rank[i] < old_rank)
					slot_rank[i]++;
			end
			slot_rank[s] = 0;
		endfunction

		function void note_item(cmd_t cmd, logic [BAND_W-1:0] band, logic wr);
			result_t r;
			int      open_n;
			int      cap;
			int      s;
			bit      found;
			r = '0;
			open_n = 0;
			accepted++;
			for (int i = 0; i < SLOTS; i++)
				open_n += slot_open[i];
			if (cmd == CMD_FLUSH) begin
				flushes++;
				for (int i = 0; i < SLOTS; i++)
					slot_open[i] = 1'b0;
				r.closed_count = COUNT_O_W'(open_n);
			end else begin
				cap = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : int'(capacity));
				found = 1'b0;
				s = 0;
				for (int i = 0; i < SLOTS && !found; i++) begin
					if (slot_open[i] && slot_band[i] == band) begin
						found = 1'b1;
						s = i;
					end
				end
				if (found) begin
					hits++;
					r.hit = 1'b1;
					if (wr && !slot_writable[s]) begin
						r.reopened_for_write = 1'b1;
						slot_writable[s] = 1'b1;
						reopens++;
					end
					promote(s, slot_rank[s]);
				end else begin
					if (open_n >= cap) begin
						for (int i = 0; i < SLOTS && !r.evicted; i++) begin
							if (slot_open[i] && slot_rank[i] + 1 == open_n) begin
								r.evicted = 1'b1;
								r.evicted_band = slot_band[i];
								slot_open[i] = 1'b0;
								evictions++;
							end
						end
						if (r.evicted)
							open_n--;
					end
					found = 1'b0;
					for (int i = 0; i < SLOTS && !found; i++) begin
						if (!slot_open[i]) begin
							found = 1'b1;
							s = i;
						end
					end
					if (found) begin
						slot_open[s] = 1'b1;
						slot_band[s] = band;
						slot_writable[s] = wr;
						promote(s, SLOTS + 1);
						open_n++;
					end
				end
				r.slot = SLOT_O_W'(s);
				r.open_count = COUNT_O_W'(open_n);
			end
			expected_results.push_back(r);
		endfunction

		function void check_field(string name, logic [BAND_W-1:0] exp, logic [BAND_W-1:0] got);
			if (exp !== got) begin
				errors++;
				$error("%s mismatch: expected %0h, got %0h", name, exp, got);
			end
		endfunction

		function void check_result(logic [47:0] data);
			result_t got;
			result_t exp;
			got = result_t'(data);
			if (expected_results.size() == 0) begin
				errors++;
				$error("result %0h arrived with no transaction pending", data);
				return;
			end
			exp = expected_results.pop_front();
			check_field("hit", exp.hit, got.hit);
			check_field("reopened_for_write", exp.reopened_for_write, got.reopened_for_write);
			check_field("evicted", exp.evicted, got.evicted);
			check_field("evicted_band", exp.evicted_band, got.evicted_band);
			check_field("slot", exp.slot, got.slot);
			check_field("open_count", exp.open_count, got.open_count);
			check_field("closed_count", exp.closed_count, got.closed_count);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [31:0]         s_axis_tdata;  // band[30:0], write_access[31]
	logic                s_axis_tuser;  // command
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// hit[0], reopened_for_write[1], evicted[2], evicted_band[33:3], slot[37:34],
	// open_count[42:38], closed_count[47:43]
	logic [47:0]         m_axis_tdata;
	logic                cfg_wr_en;
	logic [CAP_W-1:0]    cfg_wr_data;

	bit send_gaps     = 1'b1;
	bit sink_stalls   = 1'b1;
	bit long_hold_req = 1'b0;

	lru_band_scoreboard sb = new();

	open_band_lru_table #(
		.MAX_ENTRIES(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Result sink: random short stalls, plus one long hold on request.
	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 6);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Call right after a rising edge; returns at the edge that accepts the transaction.
	task automatic send_item(cmd_t cmd, logic [BAND_W-1:0] band, logic wr);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {wr, band};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(cmd, band, wr);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.capacity = value;
		@(posedge clk);
	endtask

	// Mostly a working set slightly larger than the capacity, so hits and
	// evictions both happen; some fully random bands and a few flushes.
	task automatic run_phase(int n, bit with_long_hold);
		logic [BAND_W-1:0] pool[$];
		int                cap;
		int                pick;
		int                hold_at;
		cap = (sb.capacity == 0) ? 1 : ((sb.capacity > SLOTS) ? SLOTS : int'(sb.capacity));
		for (int i = 0; i < cap + $urandom_range(1, 6); i++) begin
			if ($urandom_range(0, 2) == 0)
				pool.push_back(BAND_W'($urandom_range(0, 40)));
			else
				pool.push_back(BAND_W'($urandom()));
		end
		hold_at = with_long_hold ? $urandom_range(20, n - 20) : -1;
		for (int k = 0; k < n; k++) begin
			if (k == hold_at)
				long_hold_req = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 3)
				send_item(CMD_FLUSH, BAND_W'($urandom()), 1'($urandom()));
			else if (pick < 12)
				send_item(CMD_ACCESS, BAND_W'($urandom()), 1'($urandom()));
			else
				send_item(CMD_ACCESS, pool[$urandom_range(0, pool.size() - 1)],
					1'($urandom_range(0, 2) == 0));
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= CMD_ACCESS;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of the band field, write reopen, plain hit, flush full and empty
		send_item(CMD_ACCESS, '0, 1'b0);
		send_item(CMD_ACCESS, '1, 1'b1);
		send_item(CMD_ACCESS, '0, 1'b1);
		send_item(CMD_ACCESS, '0, 1'b0);
		send_item(CMD_ACCESS, 31'h5555_5555, 1'b0);
		send_item(CMD_ACCESS, 31'h2AAA_AAAA, 1'b1);
		send_item(CMD_FLUSH, '1, 1'b1);
		send_item(CMD_FLUSH, '0, 1'b0);
		for (int i = 1; i <= 5; i++)
			send_item(CMD_ACCESS, BAND_W'(i), i[0]);

		// shrink capacity below the open count: each miss closes only one entry
		set_capacity(CAP_W'(2));
		send_item(CMD_ACCESS, BAND_W'(9), 1'b0);
		send_item(CMD_ACCESS, BAND_W'(10), 1'b1);
		send_item(CMD_ACCESS, BAND_W'(3), 1'b1);

		// zero capacity acts as one, oversize saturates
		set_capacity(CAP_W'(0));
		send_item(CMD_ACCESS, BAND_W'(11), 1'b0);
		send_item(CMD_ACCESS, BAND_W'(11), 1'b1);
		set_capacity('1);
		send_item(CMD_ACCESS, BAND_W'(12), 1'b0);
		send_item(CMD_ACCESS, BAND_W'(13), 1'b1);

		set_capacity(CAP_RESET);
		run_phase(PHASE_LEN, 1'b0);
		set_capacity(CAP_W'(4));
		run_phase(PHASE_LEN, 1'b1);
		set_capacity(CAP_W'(1));
		run_phase(PHASE_LEN, 1'b0);
		set_capacity('1);
		run_phase(PHASE_LEN, 1'b0);
		set_capacity(CAP_W'(0));
		run_phase(PHASE_LEN, 1'b0);
		set_capacity(CAP_W'($urandom_range(1, SLOTS)));
		run_phase(PHASE_LEN, 1'b0);
		set_capacity(CAP_W'(2));
		run_phase(PHASE_LEN, 1'b0);

		// full rate on both sides to finish
		send_gaps = 1'b0;
		sink_stalls = 1'b0;
		set_capacity(CAP_RESET);
		run_phase(PHASE_LEN, 1'b0);
		repeat (10) @(posedge clk);

		$display("Ran %0d transactions, %0d of them flushes, at capacities 0, 1, 2, 4, 16, 31",
			sb.accepted, sb.flushes);
		$display("and one random; saw %0d hits, %0d write reopens, %0d evictions.",
			sb.hits, sb.reopens, sb.evictions);
		if (sb.errors == 0 && sb.expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
